// ===== rtl/core/point_light_sprite_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Point light sprite generator: assertion macros
// Shared concurrent check forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_LIGHT_SPRITE_GENERATOR_DEFINES_SVH
`define POINT_LIGHT_SPRITE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define PLSG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plsg: same-cycle check failed");

// next-cycle implication
`define PLSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plsg: next-cycle check failed");

`endif

// ===== rtl/core/plsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Point light sprite generator package
// Widths, register indexes and sequencer states shared by the core.
// ----------------------------------------------------------------------------
package plsg_pkg;

  localparam int VAL_W   = 8;            // radius, brightness, offsets
  localparam int COORD_W = 9;            // sprite row / column
  localparam int SQ_W    = 2 * VAL_W;    // one square or product
  localparam int SUM_W   = SQ_W + 1;     // dx*dx + dy*dy
  localparam int ROOT_W  = 9;            // floor root of the sum
  localparam int OP_W    = 2 * ROOT_W;   // root operand, padded to digit pairs
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] OPAQUE_BYTE     = 8'hFF;
  localparam logic [VAL_W-1:0] BRIGHTNESS_INIT = 8'hFF;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RADIUS     = 2'd0;
  localparam cfg_idx_t REG_BRIGHTNESS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_PROD,
    ST_QUOT,
    ST_EMIT
  } plsg_state_t;

endpackage

// ===== rtl/core/plsg_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiply, one 2-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module plsg_mul import plsg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [SQ_W-1:0]  product
);

  localparam int STEPS = VAL_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [VAL_W-1:0] mcand;
  logic [VAL_W-1:0] hi;
  logic [VAL_W-1:0] lo;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W+1:0] partial;
  logic [VAL_W+1:0] sum;

  always_comb begin
    case (lo[1:0])
      2'd0:    partial = '0;
      2'd1:    partial = {2'b00, mcand};
      2'd2:    partial = {1'b0, mcand, 1'b0};
      default: partial = {2'b00, mcand} + {1'b0, mcand, 1'b0};
    endcase
    sum = {2'b00, hi} + partial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        mcand <= a;
        hi    <= '0;
        lo    <= b;
      end else if (busy) begin
        hi  <= sum[VAL_W+1:2];
        lo  <= {sum[1:0], lo[VAL_W-1:2]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi, lo};

endmodule

// ===== rtl/core/plsg_sqrt.sv =====
// ----------------------------------------------------------------------------
// Serial square root
// Floor root, restoring digit-by-digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module plsg_sqrt import plsg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  operand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 1;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [OP_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W+1:0]  trial_rem;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  always_comb begin
    trial_rem = {rem, rad[OP_W-1 -: 2]};
    trial     = {{(REM_W-ROOT_W){1'b0}}, root, 2'b01};
    ge        = trial_rem >= trial;
    diff      = trial_rem - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= {{(OP_W-SUM_W){1'b0}}, operand};
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[OP_W-3:0], 2'b00};
        rem  <= ge ? diff[REM_W-1:0] : trial_rem[REM_W-1:0];
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/plsg_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle; needs num[15:8] < den.
// ----------------------------------------------------------------------------
module plsg_div import plsg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  num,
  input  logic [VAL_W-1:0] den,
  output logic             done,
  output logic [VAL_W-1:0] quot
);

  localparam int CNT_W = $clog2(VAL_W);

  logic [VAL_W-1:0] divisor;
  logic [VAL_W-1:0] rem;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W:0]   t;
  logic [VAL_W:0]   diff;
  logic             ge;

  always_comb begin
    t    = {rem, quot[VAL_W-1]};
    ge   = t >= {1'b0, divisor};
    diff = t - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        divisor <= den;
        rem     <= num[SQ_W-1:VAL_W];
        quot    <= num[VAL_W-1:0];
      end else if (busy) begin
        rem  <= ge ? diff[VAL_W-1:0] : t[VAL_W-1:0];
        quot <= {quot[VAL_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/point_light_sprite_generator.sv =====
// ----------------------------------------------------------------------------
// Point light sprite generator
// Each in_valid/in_ready transaction produces one pixel of a square light
// sprite of side 2*radius+1 in raster order; restart=1 returns to the
// top-left pixel, and the scan wraps after the bottom-right one.
// Configuration: cfg_valid/cfg_ready writes cfg_data to register cfg_index
// (0 radius, 1 brightness); cfg_ready is always high. Write only while idle.
// Result: pixel_word, pixel_row, pixel_column, last_pixel on out_valid/
// out_ready, one result per input transaction, in order.
// Timing: one pixel at a time. The squares use two serial 2-bit-digit
// multipliers in parallel, then the root follows, one bit per cycle; a pixel
// inside the radius adds the brightness product and then the divide before
// the result loads. in_ready returns the cycle after the result loads.
// The output register is separate: a new pixel is taken while the previous
// result waits; the final state holds while it waits and out_ready is low.
// Reset: radius 0, brightness 255, scan at row 0 column 0, no result pending.
// ----------------------------------------------------------------------------
`include "point_light_sprite_generator_defines.svh"

module point_light_sprite_generator import plsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  pixel_word,
  output logic [COORD_W-1:0] pixel_row,
  output logic [COORD_W-1:0] pixel_column,
  output logic               last_pixel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_idx_t           cfg_index,
  input  logic [VAL_W-1:0]   cfg_data
);

  plsg_state_t state, state_next;

  logic [VAL_W-1:0]   radius;
  logic [VAL_W-1:0]   brightness;
  logic [COORD_W-1:0] row_counter;
  logic [COORD_W-1:0] column_counter;
  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] cur_col;
  logic               last_q;
  logic               in_circle_q;

  logic [COORD_W-1:0] two_r;
  logic [COORD_W-1:0] r_ext;
  logic               wrap;
  logic [COORD_W-1:0] row_sel;
  logic [COORD_W-1:0] col_sel;
  logic [COORD_W-1:0] dx9;
  logic [COORD_W-1:0] dy9;
  logic               accept;
  logic               out_free;
  logic               in_circle;
  logic [VAL_W-1:0]   span;

  logic               mx_start, my_start, root_start, div_start, load_out;
  logic               mx_done, my_done, root_done, div_done;
  logic [SQ_W-1:0]    px, py;
  logic [VAL_W-1:0]   my_a, my_b;
  logic [SUM_W-1:0]   sq_sum;
  logic [ROOT_W-1:0]  root_q;
  logic [VAL_W-1:0]   quot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= '0;
      brightness <= BRIGHTNESS_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS:     radius     <= cfg_data;
        REG_BRIGHTNESS: brightness <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan position and offsets
  always_comb begin
    two_r   = {radius, 1'b0};
    r_ext   = {1'b0, radius};
    wrap    = restart || (row_counter > two_r) || (column_counter > two_r);
    row_sel = wrap ? '0 : row_counter;
    col_sel = wrap ? '0 : column_counter;
    dx9     = (col_sel <= r_ext) ? (r_ext - col_sel) : (col_sel - r_ext);
    dy9     = (row_sel <= r_ext) ? (r_ext - row_sel) : (row_sel - r_ext);
    accept  = in_valid && in_ready;
    out_free = !out_valid || out_ready;
    in_circle = root_q < r_ext;
    span    = radius - root_q[VAL_W-1:0];
    sq_sum  = {1'b0, px} + {1'b0, py};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (accept) begin
      cur_row <= row_sel;
      cur_col <= col_sel;
      last_q  <= (row_sel == two_r) && (col_sel == two_r);
      if (col_sel < two_r) begin
        column_counter <= col_sel + 1'b1;
        row_counter    <= row_sel;
      end else begin
        column_counter <= '0;
        row_counter    <= (row_sel < two_r) ? row_sel + 1'b1 : '0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SQ;
      ST_SQ:   if (mx_done) state_next = ST_ROOT;
      ST_ROOT: if (root_done) state_next = in_circle ? ST_PROD : ST_EMIT;
      ST_PROD: if (my_done) state_next = ST_QUOT;
      ST_QUOT: if (div_done) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = state == ST_IDLE;
    mx_start   = accept;
    my_start   = accept || (state == ST_ROOT && root_done && in_circle);
    root_start = state == ST_SQ && mx_done;
    div_start  = state == ST_PROD && my_done;
    load_out   = state == ST_EMIT && out_free;
    my_a       = (state == ST_IDLE) ? dy9[VAL_W-1:0] : brightness;
    my_b       = (state == ST_IDLE) ? dy9[VAL_W-1:0] : span;
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROOT && root_done) begin
      in_circle_q <= in_circle;
    end
  end

  plsg_mul u_mul_x (
    .clk     (clk),
    .rst     (rst),
    .start   (mx_start),
    .a       (dx9[VAL_W-1:0]),
    .b       (dx9[VAL_W-1:0]),
    .done    (mx_done),
    .product (px)
  );

  plsg_mul u_mul_y (
    .clk     (clk),
    .rst     (rst),
    .start   (my_start),
    .a       (my_a),
    .b       (my_b),
    .done    (my_done),
    .product (py)
  );

  plsg_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (sq_sum),
    .done    (root_done),
    .root    (root_q)
  );

  plsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (py),
    .den   (radius),
    .done  (div_done),
    .quot  (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_word   <= in_circle_q ? {OPAQUE_BYTE, {(WORD_W-2*VAL_W){1'b0}}, quot} : '0;
      pixel_row    <= cur_row;
      pixel_column <= cur_col;
      last_pixel   <= last_q;
    end
  end

  `PLSG_ASSERT_IMPLY(a_scan_in_sprite, clk, rst, accept,
                     (row_sel <= two_r) && (col_sel <= two_r))
  `PLSG_ASSERT_NEXT(a_emit_loads, clk, rst, load_out, out_valid && state == ST_IDLE)
  `PLSG_ASSERT_NEXT(a_outside_skips, clk, rst, state == ST_ROOT && root_done && !in_circle,
                    state == ST_EMIT && !in_circle_q)
  `PLSG_ASSERT_IMPLY(a_one_unit, clk, rst, 1'b1, $onehot0({mx_done, root_done, div_done}))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Point light sprite generator testbench
// Each pixel transaction goes through a scan-order predictor that keeps its
// own radius, brightness and row/column counters. The expected pixels wait
// in order, and every result the block returns is compared with the oldest.
// Directed cases cover reset defaults, the one-pixel sprite, wrap, a dark
// opaque centre and a radius shrink mid-scan. Random phases follow, with
// varied registers, restart noise and sender/receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  import plsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INTENSITY_CAP = 255;
  localparam int          SETTLE_CYCLES = 40;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  pixel_word;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_column;
  logic               last_pixel;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = REG_RADIUS;
  logic [VAL_W-1:0]   cfg_data = '0;

  // predictor state
  logic [VAL_W-1:0]   model_radius = '0;
  logic [VAL_W-1:0]   model_brightness = BRIGHTNESS_INIT;
  int unsigned        scan_row = 0;
  int unsigned        scan_col = 0;

  pixel_t             pixel_q[$];
  int                 error_count = 0;
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;

  point_light_sprite_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_word   (pixel_word),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .last_pixel   (last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    int b;
    root = 0;
    for (b = 8; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic pixel_t predict_pixel(input logic rs);
    int unsigned r, side, dx, dy, rdist, level;
    pixel_t p;
    r    = 32'(model_radius);
    side = 2 * r + 1;
    if (rs || scan_row >= side || scan_col >= side) begin
      scan_row = 0;
      scan_col = 0;
    end
    dx   = (scan_col <= r) ? r - scan_col : scan_col - r;
    dy   = (scan_row <= r) ? r - scan_row : scan_row - r;
    rdist = floor_root(dx * dx + dy * dy);
    p.word = '0;
    if (rdist < r) begin
      level = (model_brightness * (r - rdist)) / r;
      if (level > INTENSITY_CAP) level = INTENSITY_CAP;
      p.word = {OPAQUE_BYTE, 24'h0} | level;
    end
    p.row  = COORD_W'(scan_row);
    p.col  = COORD_W'(scan_col);
    p.last = (scan_row == side - 1) && (scan_col == side - 1);
    if (scan_col + 1 < side) begin
      scan_col = scan_col + 1;
    end else begin
      scan_col = 0;
      scan_row = (scan_row + 1 < side) ? scan_row + 1 : 0;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("%0t: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected result", pixel_word, 0);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_word !== want.word) report_mismatch("pixel_word", pixel_word, want.word);
        if (pixel_row !== want.row)
          report_mismatch("pixel_row", 32'(pixel_row), 32'(want.row));
        if (pixel_column !== want.col)
          report_mismatch("pixel_column", 32'(pixel_column), 32'(want.col));
        if (last_pixel !== want.last)
          report_mismatch("last_pixel", 32'(last_pixel), 32'(want.last));
      end
    end
  end

  task automatic send_pixel(input logic rs);
    pixel_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_pixel(rs);
    pixel_q.push_back(p);
  endtask

  task automatic hold_until_drained(input int tail);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [VAL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_RADIUS) model_radius = val;
    else if (idx == REG_BRIGHTNESS) model_brightness = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 61; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 61; end
      default: begin idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic run_phase(input int n, input logic [VAL_W-1:0] r,
                           input logic [VAL_W-1:0] b, input int mode,
                           input int unsigned restart_pct);
    int k;
    write_reg(REG_RADIUS, r);
    write_reg(REG_BRIGHTNESS, b);
    set_idling(mode);
    send_pixel(1'b1);
    for (k = 1; k < n; k++) begin
      // sender holds off until every pending pixel is back
      if (k == n / 2) hold_until_drained(0);
      send_pixel($urandom_range(99) < restart_pct);
    end
    hold_until_drained(SETTLE_CYCLES);
  endtask

  // radius 0 out of reset: one blank pixel, last every time
  task automatic test_reset_state;
    set_idling(0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    hold_until_drained(SETTLE_CYCLES);
  endtask

  // full 3x3 scan and wrap to the top-left
  task automatic test_scan_wrap;
    int k;
    write_reg(REG_RADIUS, 8'd1);
    write_reg(REG_BRIGHTNESS, 8'd255);
    send_pixel(1'b1);
    for (k = 0; k < 9; k++) send_pixel(1'b0);
    hold_until_drained(SETTLE_CYCLES);
  endtask

  // zero brightness: centre opaque with no intensity
  task automatic test_dark_centre;
    int k;
    write_reg(REG_BRIGHTNESS, 8'd0);
    send_pixel(1'b1);
    for (k = 0; k < 4; k++) send_pixel(1'b0);
    hold_until_drained(SETTLE_CYCLES);
  endtask

  // shrink the radius while the column lies beyond the new side
  task automatic test_radius_shrink;
    int k;
    write_reg(REG_RADIUS, 8'd2);
    write_reg(REG_BRIGHTNESS, 8'd200);
    send_pixel(1'b1);
    for (k = 0; k < 3; k++) send_pixel(1'b0);
    hold_until_drained(SETTLE_CYCLES);
    write_reg(REG_RADIUS, 8'd1);
    send_pixel(1'b0);
    send_pixel(1'b0);
    hold_until_drained(SETTLE_CYCLES);
  endtask

  // largest radius: first row across all columns and into the next
  task automatic test_wide_sprite;
    run_phase(515, 8'd255, 8'd255, 0, 0);
  endtask

  task automatic test_random_sprites;
    int k;
    logic [VAL_W-1:0] r, b;
    int unsigned restart_pct;
    for (k = 0; k < 12; k++) begin
      case (k)
        0:       r = 8'd0;
        1:       r = 8'd1;
        2:       r = 8'd254;
        default: r = VAL_W'($urandom_range(1, 5));
      endcase
      case (k)
        1, 6:    b = 8'd0;
        2:       b = 8'd255;
        default: b = VAL_W'($urandom_range(0, 255));
      endcase
      restart_pct = (k == 5 || k == 9) ? 40 : 3;
      run_phase(40, r, b, k % 4, restart_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_scan_wrap();
    test_dark_centre();
    test_radius_shrink();
    test_wide_sprite();
    test_random_sprites();
    if (pixel_q.size() != 0) report_mismatch("missing result", pixel_q.size(), 0);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
